FILE: hdl/hll_pkg.sv
// Shared types, constants and the FNV step for the HyperLogLog sketch update block.
`default_nettype none

package hll_pkg;

    localparam int MAX_PRECISION = 17;
    localparam int MIN_PRECISION = 4;
    localparam int RESET_PRECISION = 14;

    localparam int HASH_W = 64;
    localparam int PREC_W = 5;
    localparam int VAL_W = 6;
    localparam int IDX_W = MAX_PRECISION;
    localparam int ZC_W = MAX_PRECISION + 1;
    localparam int SKETCH_DEPTH = 1 << MAX_PRECISION;

    localparam logic [PREC_W-1:0] PREC_MIN = PREC_W'(MIN_PRECISION);
    localparam logic [PREC_W-1:0] PREC_MAX = PREC_W'(MAX_PRECISION);
    localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(RESET_PRECISION);

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    typedef enum logic [1:0] {
        CMD_KEY_BYTE = 2'd0,
        CMD_PREHASH  = 2'd1,
        CMD_CLEAR    = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [7:0]        data_byte;
        logic              last_byte;
        logic [HASH_W-1:0] hash_value;
    } t_item;

    typedef struct packed {
        logic [HASH_W-1:0] key_hash;
        logic [IDX_W-1:0]  register_index;
        logic [VAL_W-1:0]  register_value;
        logic              was_raised;
        logic [ZC_W-1:0]   zero_registers;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RANK,
        ST_UPDATE,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic fnv_step;
        logic key_done;
        logic load_pre;
        logic sweep_start;
        logic sweep_write;
        logic sweep_end;
        logic report_clear;
        logic scan;
        logic rank;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
    } t_dp_stat;

    // One FNV-1a step. The prime is 2^40 + 0x1b3, so the product modulo 2^64
    // reduces to a handful of shifted adds.
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-8){1'b0}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hll_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module hll_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 131072
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/hll_ctrl.sv
// Controller state machine: sequences key updates and clearing sweeps.
`default_nettype none

module hll_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire hll_pkg::t_cmd     i_cmd,
    input  wire logic              i_last,
    input  wire logic              i_cfg_we,
    input  wire hll_pkg::t_dp_stat i_stat,
    output hll_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);

    hll_pkg::t_state r_state, n_state;
    logic            r_report, n_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hll_pkg::ST_CLEAR;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_report = r_report;
        unique case (r_state)
            hll_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd)
                        hll_pkg::CMD_KEY_BYTE: begin
                            if (i_last) begin
                                n_state = hll_pkg::ST_SCAN;
                            end
                        end
                        hll_pkg::CMD_PREHASH: begin
                            n_state = hll_pkg::ST_SCAN;
                        end
                        hll_pkg::CMD_CLEAR: begin
                            n_state  = hll_pkg::ST_CLEAR;
                            n_report = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            hll_pkg::ST_SCAN:   n_state = hll_pkg::ST_RANK;
            hll_pkg::ST_RANK:   n_state = hll_pkg::ST_UPDATE;
            hll_pkg::ST_UPDATE: n_state = hll_pkg::ST_IDLE;
            hll_pkg::ST_CLEAR: begin
                if (i_stat.sweep_last) begin
                    n_state = hll_pkg::ST_IDLE;
                end
            end
            default: n_state = hll_pkg::ST_IDLE;
        endcase
        // A precision write restarts the sweep and the sketch comes up silently.
        if (i_cfg_we) begin
            n_state  = hll_pkg::ST_CLEAR;
            n_report = 1'b0;
        end
    end

    always_comb begin
        logic idle_start;
        idle_start = (r_state == hll_pkg::ST_IDLE) && i_start;
        o_cmd = '0;
        o_cmd.fnv_step    = idle_start && (i_cmd == hll_pkg::CMD_KEY_BYTE);
        o_cmd.key_done    = idle_start && (i_cmd == hll_pkg::CMD_KEY_BYTE) && i_last;
        o_cmd.load_pre    = idle_start && (i_cmd == hll_pkg::CMD_PREHASH);
        o_cmd.sweep_start = i_cfg_we || (idle_start && (i_cmd == hll_pkg::CMD_CLEAR));
        o_cmd.sweep_write = (r_state == hll_pkg::ST_CLEAR);
        o_cmd.sweep_end   = (r_state == hll_pkg::ST_CLEAR) && i_stat.sweep_last;
        o_cmd.report_clear = o_cmd.sweep_end && r_report && !i_cfg_we;
        o_cmd.scan        = (r_state == hll_pkg::ST_SCAN);
        o_cmd.rank        = (r_state == hll_pkg::ST_RANK);
        o_cmd.update      = (r_state == hll_pkg::ST_UPDATE);
        o_busy            = (r_state != hll_pkg::ST_IDLE);
    end

endmodule

`default_nettype wire

FILE: hdl/hll_dp.sv
// Datapath: FNV hashing, rank computation, sketch RAM update and result register.
`default_nettype none

module hll_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire hll_pkg::t_item               i_item,
    input  wire logic                         i_cfg_we,
    input  wire logic [hll_pkg::PREC_W-1:0]   i_cfg_data,
    input  wire hll_pkg::t_dp_cmd             i_cmd,
    output hll_pkg::t_dp_stat                 o_stat,
    output hll_pkg::t_result                  o_result,
    output logic                              o_valid
);

    logic [hll_pkg::PREC_W-1:0] r_prec;
    logic [hll_pkg::HASH_W-1:0] r_run;
    logic [hll_pkg::HASH_W-1:0] r_hash;
    logic [hll_pkg::IDX_W-1:0]  r_sweep;
    logic [hll_pkg::ZC_W-1:0]   r_zero, n_zero;
    logic [7:0]                 r_lane_nz;
    logic [2:0]                 r_lane_lz [8];
    logic [hll_pkg::VAL_W-1:0]  r_rank;
    hll_pkg::t_result           r_out;
    logic                       r_valid;

    logic [hll_pkg::PREC_W-1:0] prec_sat;
    logic [hll_pkg::ZC_W-1:0]   span, span_m1;
    logic [hll_pkg::IDX_W-1:0]  mask, idx;
    logic [hll_pkg::HASH_W-1:0] fnv_next;
    logic [6:0]                 clz, cap, clz_cap;
    logic [hll_pkg::VAL_W-1:0]  old_val, new_val, ram_wdata;
    logic                       raised, ram_we;
    logic [hll_pkg::IDX_W-1:0]  ram_addr;

    function automatic logic [2:0] lz8(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                n = 3'(7 - i);
            end
        end
        return n;
    endfunction

    always_comb begin
        prec_sat = i_cfg_data;
        if (i_cfg_data < hll_pkg::PREC_MIN) begin
            prec_sat = hll_pkg::PREC_MIN;
        end else if (i_cfg_data > hll_pkg::PREC_MAX) begin
            prec_sat = hll_pkg::PREC_MAX;
        end
    end

    assign span     = {{hll_pkg::IDX_W{1'b0}}, 1'b1} << r_prec;
    assign span_m1  = span - {{hll_pkg::IDX_W{1'b0}}, 1'b1};
    assign mask     = span_m1[hll_pkg::IDX_W-1:0];
    assign idx      = r_hash[hll_pkg::IDX_W-1:0] & mask;
    assign fnv_next = hll_pkg::fnv_step(r_run, i_item.data_byte);

    assign o_stat.sweep_last = (r_sweep == mask);

    // Leading zeros of the whole hash, assembled from the per-byte counts.
    always_comb begin
        clz = 7'd64;
        for (int k = 0; k < 8; k++) begin
            if (r_lane_nz[k]) begin
                clz = 7'(8 * (7 - k)) + {4'b0, r_lane_lz[k]};
            end
        end
        cap     = 7'd64 - {2'b0, r_prec};
        clz_cap = (clz < cap) ? clz : cap;
    end

    assign raised  = i_cmd.update && (r_rank > old_val);
    assign new_val = raised ? r_rank : old_val;

    always_comb begin
        n_zero = r_zero;
        if (raised && (old_val == '0) && (r_zero != '0)) begin
            n_zero = r_zero - {{(hll_pkg::ZC_W-1){1'b0}}, 1'b1};
        end
    end

    assign ram_we    = i_cmd.sweep_write || raised;
    assign ram_addr  = i_cmd.sweep_write ? r_sweep : idx;
    assign ram_wdata = i_cmd.sweep_write ? '0 : r_rank;

    hll_ram #(
        .WIDTH(hll_pkg::VAL_W),
        .DEPTH(hll_pkg::SKETCH_DEPTH)
    ) u_sketch (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(old_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec  <= hll_pkg::PREC_RESET;
            r_run   <= hll_pkg::FNV_BASIS;
            r_sweep <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prec <= prec_sat;
            end
            if (i_cmd.key_done) begin
                r_run <= hll_pkg::FNV_BASIS;
            end else if (i_cmd.fnv_step) begin
                r_run <= fnv_next;
            end
            if (i_cmd.sweep_start) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_write) begin
                r_sweep <= r_sweep + {{(hll_pkg::IDX_W-1){1'b0}}, 1'b1};
            end
            r_valid <= i_cmd.update || i_cmd.report_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_done) begin
            r_hash <= fnv_next;
        end else if (i_cmd.load_pre) begin
            r_hash <= i_item.hash_value;
        end
        if (i_cmd.scan) begin
            for (int k = 0; k < 8; k++) begin
                r_lane_nz[k] <= |r_hash[8*k +: 8];
                r_lane_lz[k] <= lz8(r_hash[8*k +: 8]);
            end
        end
        if (i_cmd.rank) begin
            r_rank <= clz_cap[hll_pkg::VAL_W-1:0] + {{(hll_pkg::VAL_W-1){1'b0}}, 1'b1};
        end
        if (i_cmd.sweep_end) begin
            r_zero <= span;
        end else if (i_cmd.update) begin
            r_zero <= n_zero;
        end
        if (i_cmd.update) begin
            r_out.key_hash       <= r_hash;
            r_out.register_index <= idx;
            r_out.register_value <= new_val;
            r_out.was_raised     <= raised;
            r_out.zero_registers <= n_zero;
        end else if (i_cmd.report_clear) begin
            r_out                <= '0;
            r_out.zero_registers <= span;
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_valid;

endmodule

`default_nettype wire

FILE: hdl/hyperloglog_sketch_update.sv
// Top level of the HyperLogLog sketch update block.
//
//  Channel   Handshake                 Payload
//  input     start, busy               i_item   (hll_pkg::t_item)
//  result    o_valid (one cycle)       o_result (hll_pkg::t_result)
//  config    i_cfg_we                  i_cfg_data (precision, saturated to 4..17)
//
// A key byte that is not last, or an unused command, is taken in idle; busy stays low.
// A last key byte or a prehashed value holds busy high through the byte leading-zero scan,
// rank and RAM read, and read-modify-write states; the strobe is high in the cycle after the
// update, and no new key is taken until busy drops. The receiver cannot stall the block.
// Reset, a precision write and a clear sweep the 2^p sketch entries, one a cycle with busy
// high (2^14 entries after reset); a clear reports its result when its sweep ends.
`default_nettype none

module hyperloglog_sketch_update (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire hll_pkg::t_item             i_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [hll_pkg::PREC_W-1:0] i_cfg_data,
    output logic                            busy,
    output logic                            o_valid,
    output hll_pkg::t_result                o_result
);

    hll_pkg::t_dp_cmd  s_cmd;
    hll_pkg::t_dp_stat s_stat;

    hll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_item.cmd),
        .i_last  (i_item.last_byte),
        .i_cfg_we(i_cfg_we),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd),
        .o_busy  (busy)
    );

    hll_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (s_cmd),
        .o_stat    (s_stat),
        .o_result  (o_result),
        .o_valid   (o_valid)
    );

    // Results are never reported in consecutive cycles.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two results in consecutive cycles");

    // A raised register always holds a non-zero rank.
    a_raised_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.was_raised) |-> (o_result.register_value != '0))
        else $error("raised register reports zero");

    // The rank stage is always followed by the update unless a sweep intervenes.
    a_rank_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.rank && !i_cfg_we) |=> s_cmd.update)
        else $error("rank stage not followed by update");

    // A key transfer never happens while a sweep is writing the RAM.
    a_no_key_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.sweep_write |-> !(s_cmd.load_pre || s_cmd.key_done))
        else $error("key accepted during clearing sweep");

endmodule

`default_nettype wire
